>>> rtl/cla_pkg.sv
package cla_pkg;

    // list operation codes
    typedef enum logic [3:0] {
        FN_INS_BEFORE = 4'd0,
        FN_INS_AFTER  = 4'd1,
        FN_GET        = 4'd2,
        FN_REMOVE     = 4'd3,
        FN_CLEAR      = 4'd4,
        FN_BEGIN      = 4'd5,
        FN_END        = 4'd6,
        FN_NEXT       = 4'd7,
        FN_PRIOR      = 4'd8
    } t_func;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;
    localparam int POS_W   = 6;
    localparam int CAP_W   = 7;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;
    // register index, taken from the word address bit
    localparam logic             REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [3:0]               func;
        logic signed [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                      ok;
        logic signed [WORD_W-1:0]  read_value;
        logic [COUNT_W-1:0]        count;
        logic [POS_W-1:0]          position;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_GET,
        S_RM_CAP,
        S_DN_RD,
        S_DN_WR,
        S_UP_RD,
        S_UP_WR,
        S_REPORT
    } t_state;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_INC,
        CUR_DEC,
        CUR_LAST
    } t_cur_op;

    typedef enum logic [2:0] {
        HELD_HOLD,
        HELD_ZERO,
        HELD_INC,
        HELD_DEC
    } t_held_op;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_HELD,
        PTR_CUR,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_PTR_DEC,
        RD_PTR_INC
    } t_rd_sel;

    typedef enum logic {
        WR_VALUE,
        WR_RDATA
    } t_wr_sel;

    typedef struct packed {
        logic     latch;
        logic     set_ok;
        logic     cap_rd;
        logic     report;
        t_cur_op  cur_op;
        t_held_op held_op;
        t_ptr_op  ptr_op;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  empty;
        logic  full;
        logic  at_begin;
        logic  at_end;
        logic  ptr_gt_cur;
        logic  ptr_inc_lt_held;
    } t_status;

endpackage

>>> rtl/cla_ram.sv
module cla_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 64
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic                     i_re,
        input  logic [$clog2(DEPTH)-1:0] i_raddr,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cla_ctrl.sv
module cla_ctrl
    import cla_pkg::*;
    (
        input  logic    i_clk,
        input  logic    i_rst_n,
        input  logic    i_start,
        input  t_status i_status,
        output logic    o_busy,
        output t_cmd    o_cmd
    );

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = !((r_state == S_IDLE) || (r_state == S_REPORT));
    assign accept = i_start && !o_busy;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.cur_op  = CUR_HOLD;
        o_cmd.held_op = HELD_HOLD;
        o_cmd.ptr_op  = PTR_HOLD;
        o_cmd.rd_sel  = RD_CUR;
        o_cmd.wr_sel  = WR_VALUE;
        o_cmd.latch   = accept;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = accept ? S_EXEC : S_IDLE;
            end
            S_EXEC: begin
                n_state = S_REPORT;
                unique case (i_status.func)
                    FN_INS_BEFORE, FN_INS_AFTER: begin
                        if (!i_status.full) begin
                            if (i_status.func == FN_INS_AFTER && !i_status.empty) begin
                                o_cmd.cur_op = CUR_INC;
                            end
                            o_cmd.ptr_op = PTR_HELD;
                            n_state      = S_UP_RD;
                        end
                    end
                    FN_GET: begin
                        if (!i_status.empty) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_CUR;
                            n_state      = S_GET;
                        end
                    end
                    FN_REMOVE: begin
                        if (!i_status.empty) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_CUR;
                            o_cmd.ptr_op = PTR_CUR;
                            n_state      = S_RM_CAP;
                        end
                    end
                    FN_CLEAR: begin
                        o_cmd.held_op = HELD_ZERO;
                        o_cmd.cur_op  = CUR_ZERO;
                        o_cmd.set_ok  = 1'b1;
                    end
                    FN_BEGIN: begin
                        if (!i_status.empty) begin
                            o_cmd.cur_op = CUR_ZERO;
                            o_cmd.set_ok = 1'b1;
                        end
                    end
                    FN_END: begin
                        if (!i_status.empty) begin
                            o_cmd.cur_op = CUR_LAST;
                            o_cmd.set_ok = 1'b1;
                        end
                    end
                    FN_NEXT: begin
                        if (!i_status.empty && !i_status.at_end) begin
                            o_cmd.cur_op = CUR_INC;
                            o_cmd.set_ok = 1'b1;
                        end
                    end
                    FN_PRIOR: begin
                        if (!i_status.empty && !i_status.at_begin) begin
                            o_cmd.cur_op = CUR_DEC;
                            o_cmd.set_ok = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_GET: begin
                o_cmd.cap_rd = 1'b1;
                o_cmd.set_ok = 1'b1;
                n_state      = S_REPORT;
            end
            S_RM_CAP: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_status.ptr_inc_lt_held) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PTR_INC;
                    n_state      = S_DN_WR;
                end else begin
                    o_cmd.held_op = HELD_DEC;
                    if (i_status.at_end && !i_status.at_begin) begin
                        o_cmd.cur_op = CUR_DEC;
                    end
                    o_cmd.set_ok = 1'b1;
                    n_state      = S_REPORT;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_RDATA;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_DN_RD;
            end
            S_UP_RD: begin
                if (i_status.ptr_gt_cur) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PTR_DEC;
                    n_state      = S_UP_WR;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_VALUE;
                    o_cmd.held_op = HELD_INC;
                    o_cmd.set_ok  = 1'b1;
                    n_state       = S_REPORT;
                end
            end
            S_UP_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_RDATA;
                o_cmd.ptr_op = PTR_DEC;
                n_state      = S_UP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/cla_dp.sv
module cla_dp
    import cla_pkg::*;
    #(
        parameter int DEPTH = 64
    )
    (
        input  logic             i_clk,
        input  logic             i_rst_n,
        input  t_in_item         i_item,
        input  logic [CAP_W-1:0] i_capacity,
        input  t_cmd             i_cmd,
        output t_status          o_status,
        output logic             o_valid,
        output t_out_item        o_result
    );

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [3:0]        r_func;
    logic [WORD_W-1:0] r_value;
    logic [CW-1:0]     r_held;
    logic [CW-1:0]     n_held;
    logic [AW-1:0]     r_cursor;
    logic [AW-1:0]     n_cursor;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     n_ptr;
    logic              r_ok;
    logic [WORD_W-1:0] r_rd;
    logic              r_valid;
    t_out_item         r_result;

    logic [CW-1:0]     held_dec;
    logic [CW-1:0]     cursor_inc;
    logic [CW-1:0]     ptr_inc;
    logic [EW-1:0]     cap_ext;
    logic [EW-1:0]     eff_cap;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] ram_wdata;

    assign held_dec   = r_held - CW'(1);
    assign cursor_inc = CW'(r_cursor) + CW'(1);
    assign ptr_inc    = CW'(r_ptr) + CW'(1);
    assign cap_ext    = EW'(i_capacity);
    assign eff_cap    = (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;

    assign o_status.func            = t_func'(r_func);
    assign o_status.empty           = (r_held == '0);
    assign o_status.full            = (EW'(r_held) >= eff_cap);
    assign o_status.at_begin        = (r_cursor == '0);
    assign o_status.at_end          = (cursor_inc == r_held);
    assign o_status.ptr_gt_cur      = (r_ptr > r_cursor);
    assign o_status.ptr_inc_lt_held = (ptr_inc < r_held);

    always_comb begin
        unique case (i_cmd.held_op)
            HELD_ZERO: n_held = '0;
            HELD_INC:  n_held = r_held + CW'(1);
            HELD_DEC:  n_held = held_dec;
            default:   n_held = r_held;
        endcase

        unique case (i_cmd.cur_op)
            CUR_ZERO: n_cursor = '0;
            CUR_INC:  n_cursor = cursor_inc[AW-1:0];
            CUR_DEC:  n_cursor = r_cursor - AW'(1);
            CUR_LAST: n_cursor = held_dec[AW-1:0];
            default:  n_cursor = r_cursor;
        endcase

        unique case (i_cmd.ptr_op)
            PTR_HELD: n_ptr = r_held[AW-1:0];
            PTR_CUR:  n_ptr = r_cursor;
            PTR_INC:  n_ptr = ptr_inc[AW-1:0];
            PTR_DEC:  n_ptr = r_ptr - AW'(1);
            default:  n_ptr = r_ptr;
        endcase

        unique case (i_cmd.rd_sel)
            RD_PTR_DEC: ram_raddr = r_ptr - AW'(1);
            RD_PTR_INC: ram_raddr = ptr_inc[AW-1:0];
            default:    ram_raddr = r_cursor;
        endcase
    end

    assign ram_re    = i_cmd.rd_en;
    assign ram_wdata = (i_cmd.wr_sel == WR_RDATA) ? ram_rdata : r_value;

    cla_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_ptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_held   <= n_held;
            r_cursor <= n_cursor;
            r_valid  <= i_cmd.report;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.latch) begin
            r_func  <= i_item.func;
            r_value <= i_item.value;
            r_ok    <= 1'b0;
            r_rd    <= '0;
        end else begin
            if (i_cmd.set_ok) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.cap_rd) begin
                r_rd <= ram_rdata;
            end
        end
        if (i_cmd.report) begin
            r_result.ok         <= r_ok;
            r_result.read_value <= r_rd;
            r_result.count      <= COUNT_W'(r_held);
            r_result.position   <= POS_W'(r_cursor);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/cursor_list_array.sv
// cursor list array: ordered list of 32-bit words with a cursor, one item at a time
// steps: cursor moves, clear and failed operations report straight after decode; a get that
//   succeeds first captures the word; insert shifts the tail up to open the insert point; remove
//   captures the word, then shifts the tail down over it; the next item is taken at the edge
//   that opens the previous item's strobe; each moved word is read, then written
// sync reset: list empty, cursor 0, capacity 64, ram not cleared; receiver cannot stall o_valid
module cursor_list_array
    import cla_pkg::*;
    #(
        parameter int DEPTH = 64
    )
    (
        input  logic               i_clk,
        input  logic               i_rst_n,

        // item channel: transfer when start is high and busy is low
        input  logic               start,
        output logic               busy,
        input  t_in_item           i_item,

        // result channel: one cycle strobe, no back pressure
        output logic               o_valid,
        output t_out_item          o_result,

        // register port
        input  logic               psel,
        input  logic               penable,
        input  logic               pwrite,
        input  logic [PADDR_W-1:0] paddr,
        input  logic [APB_W-1:0]   pwdata,
        output logic [APB_W-1:0]   prdata,
        output logic               pready
    );

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_write;
    t_cmd             cmd;
    t_status          status;

    // register writes land on the access phase; pready is tied high
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // only the capacity register exists; other word addresses read as zero
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_W'(r_capacity) : '0;

    // sequencer: decodes the item and steps the shift loop
    cla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // count, cursor, shift pointer, entry ram and result register
    cla_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_capacity (r_capacity),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

>>> tb/cursor_list_array_tb.sv
module cursor_list_array_tb
    import cla_pkg::*;
    ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH     = 64;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    // the longest transfer is a remove at word 0 of a full list
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int SETTLE_CYCLES  = 4;

    // func codes past the last operation, which the block must ignore
    localparam logic [3:0] FN_UNUSED_LO = 4'd9;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;

    // capacity is register 0, so byte address 0
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

    // one row of the directed script: either a capacity write or a list operation
    typedef struct {
        bit                 cap_write;
        logic [CAP_W-1:0]   cap;
        logic [3:0]         func;
        logic [WORD_W-1:0]  value;
        bit                 typed;
        t_out_item          want;
    } t_script_row;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    t_in_item           i_item   = '0;
    logic               o_valid;
    t_out_item          o_result;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [APB_W-1:0]   pwdata   = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    // sideband that rides along with i_item: a typed-in result for directed rows
    logic               item_is_typed     = 1'b0;
    t_out_item          item_typed_result = '0;

    // shadow of the list, kept in step with every item transfer
    logic [WORD_W-1:0]  list_store [LIST_DEPTH];
    logic [COUNT_W-1:0] list_count  = '0;
    logic [POS_W-1:0]   list_cursor = '0;
    logic [CAP_W-1:0]   cap_shadow  = CAP_RESET;

    t_out_item          pending_reports [$];
    t_script_row        script [$];
    int                 fail_count      = 0;
    int                 stall_cycles    = 0;
    int                 sender_idle_pct = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    cursor_list_array #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .*
    );

    // apply one list operation to the shadow and return what the block should report
    function automatic t_out_item apply_list_op(t_in_item item);
        t_out_item r;
        int        eff;
        int        i;
        r   = '0;
        eff = (int'(cap_shadow) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_shadow);
        case (item.func)
            FN_INS_BEFORE, FN_INS_AFTER: begin
                // full when the count has reached the clamped capacity
                if (int'(list_count) < eff) begin
                    if (list_count == 0) begin
                        list_store[0] = item.value;
                        list_cursor   = '0;
                        list_count    = COUNT_W'(1);
                    end else begin
                        if (item.func == FN_INS_AFTER)
                            list_cursor++;
                        // open a slot at the cursor by shifting the tail up
                        for (i = int'(list_count); i > int'(list_cursor); i--)
                            list_store[i] = list_store[i-1];
                        list_store[list_cursor] = item.value;
                        list_count++;
                    end
                    r.ok = 1'b1;
                end
            end
            FN_GET: begin
                if (list_count != 0) begin
                    r.read_value = list_store[list_cursor];
                    r.ok         = 1'b1;
                end
            end
            FN_REMOVE: begin
                if (list_count != 0) begin
                    r.read_value = list_store[list_cursor];
                    for (i = int'(list_cursor); i + 1 < int'(list_count); i++)
                        list_store[i] = list_store[i+1];
                    list_count--;
                    // cursor falls back to the new last word, or 0 once empty
                    if (list_count == 0)
                        list_cursor = '0;
                    else if (int'(list_cursor) >= int'(list_count))
                        list_cursor = POS_W'(int'(list_count) - 1);
                    r.ok = 1'b1;
                end
            end
            FN_CLEAR: begin
                list_count  = '0;
                list_cursor = '0;
                r.ok        = 1'b1;
            end
            FN_BEGIN: begin
                if (list_count != 0) begin
                    list_cursor = '0;
                    r.ok        = 1'b1;
                end
            end
            FN_END: begin
                if (list_count != 0) begin
                    list_cursor = POS_W'(int'(list_count) - 1);
                    r.ok        = 1'b1;
                end
            end
            FN_NEXT: begin
                if (list_count != 0 && int'(list_cursor) + 1 < int'(list_count)) begin
                    list_cursor++;
                    r.ok = 1'b1;
                end
            end
            FN_PRIOR: begin
                if (list_count != 0 && list_cursor != 0) begin
                    list_cursor--;
                    r.ok = 1'b1;
                end
            end
            default: begin
                // unused codes change nothing
            end
        endcase
        r.count    = list_count;
        r.position = list_cursor;
        return r;
    endfunction

    // monitor: results are checked in order, item transfers feed the shadow
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            // result first: an item can be taken in the very cycle the last one reports
            if (o_valid) begin
                moved = 1'b1;
                if (pending_reports.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_result.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, o_result.ok);
                        fail_count++;
                    end
                    if (o_result.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, o_result.read_value);
                        fail_count++;
                    end
                    if (o_result.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_result.count);
                        fail_count++;
                    end
                    if (o_result.position !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, o_result.position);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                want  = apply_list_op(i_item);
                // directed rows with a typed-in result are held to that result
                pending_reports.push_back(item_is_typed ? item_typed_result : want);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // offer one item and hold it until the transfer, then maybe go quiet a while
    task automatic send_item(input logic [3:0] func, input logic [WORD_W-1:0] value,
                             input bit typed, input t_out_item want);
        i_item            <= '{func: func, value: value};
        item_is_typed     <= typed;
        item_typed_result <= want;
        start             <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        // transfer happened at this edge; start stays high unless we idle
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // one apb transfer to the capacity register: setup cycle, then access until pready
    task automatic reg_access(input bit wr, input logic [APB_W-1:0] wdata,
                              output logic [APB_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // capacity only changes with the block idle and every result collected
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [APB_W-1:0] readback;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        reg_access(1'b1, APB_W'(cap), readback);
        cap_shadow = cap;
        @(posedge i_clk);
        reg_access(1'b0, '0, readback);
        if (readback[CAP_W-1:0] !== cap) begin
            $error("capacity: expected %0d, got %0d", cap, readback[CAP_W-1:0]);
            fail_count++;
        end
    endtask

    // mostly random words, with the corners of the signed range mixed in
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // growing leans on inserts to reach full, shrinking on removes to reach empty
    function automatic logic [3:0] random_op(input bit growing);
        int roll;
        int ins_pct;
        int rm_pct;
        roll    = $urandom_range(99);
        ins_pct = growing ? 60 : 12;
        rm_pct  = growing ? 8 : 55;
        if (roll < ins_pct)
            return $urandom_range(1) ? FN_INS_AFTER : FN_INS_BEFORE;
        if (roll < ins_pct + rm_pct)
            return FN_REMOVE;
        if (roll < 96) begin
            case ($urandom_range(4))
                0:       return FN_GET;
                1:       return FN_BEGIN;
                2:       return FN_END;
                3:       return FN_NEXT;
                default: return FN_PRIOR;
            endcase
        end
        if (roll < 98)
            return 4'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
        // clear only while draining, so the fill can still reach capacity
        return growing ? FN_GET : FN_CLEAR;
    endfunction

    // one capacity setting, then a sawtooth of fill and drain with random content
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle_pct, input int n);
        int eff;
        int left;
        int k;
        bit growing;
        set_capacity(cap);
        sender_idle_pct = idle_pct;
        eff     = (int'(cap) > LIST_DEPTH) ? LIST_DEPTH : int'(cap);
        growing = 1'b1;
        left    = 2 * eff + 6;
        for (k = 0; k < n; k++) begin
            if (left == 0) begin
                growing = !growing;
                left    = (growing ? 2 : 3) * eff + 6;
            end
            left--;
            send_item(random_op(growing), random_word(), 1'b0, '0);
        end
    endtask

    function automatic void script_op(input logic [3:0] func, input logic [WORD_W-1:0] value);
        t_script_row row;
        row       = '{default: '0};
        row.func  = func;
        row.value = value;
        script.push_back(row);
    endfunction

    function automatic void script_typed(input logic [3:0] func,
                                         input logic [WORD_W-1:0] value,
                                         input logic ok, input logic [WORD_W-1:0] rd,
                                         input logic [COUNT_W-1:0] cnt,
                                         input logic [POS_W-1:0] pos);
        t_script_row row;
        row                 = '{default: '0};
        row.func            = func;
        row.value           = value;
        row.typed           = 1'b1;
        row.want.ok         = ok;
        row.want.read_value = rd;
        row.want.count      = cnt;
        row.want.position   = pos;
        script.push_back(row);
    endfunction

    function automatic void script_capacity(input logic [CAP_W-1:0] cap);
        t_script_row row;
        row           = '{default: '0};
        row.cap_write = 1'b1;
        row.cap       = cap;
        script.push_back(row);
    endfunction

    initial begin
        // empty list: every read and cursor move fails, unused code is a no-op
        script_typed(FN_GET,       32'h0, 1'b0, 32'h0, 7'd0, 6'd0);
        script_typed(FN_REMOVE,    32'h0, 1'b0, 32'h0, 7'd0, 6'd0);
        script_typed(FN_BEGIN,     32'h0, 1'b0, 32'h0, 7'd0, 6'd0);
        script_typed(FN_END,       32'h0, 1'b0, 32'h0, 7'd0, 6'd0);
        script_typed(FN_NEXT,      32'h0, 1'b0, 32'h0, 7'd0, 6'd0);
        script_typed(FN_PRIOR,     32'h0, 1'b0, 32'h0, 7'd0, 6'd0);
        script_typed(FN_UNUSED_HI, 32'hFFFF_FFFF, 1'b0, 32'h0, 7'd0, 6'd0);
        // first insert into an empty list lands at word 0 whichever side is asked
        script_typed(FN_INS_AFTER,  32'h7FFF_FFFF, 1'b1, 32'h0, 7'd1, 6'd0);
        script_typed(FN_GET,        32'h0, 1'b1, 32'h7FFF_FFFF, 7'd1, 6'd0);
        script_typed(FN_INS_BEFORE, 32'h8000_0000, 1'b1, 32'h0, 7'd2, 6'd0);
        script_op(FN_INS_AFTER, 32'hFFFF_FFFF);
        // walk to the end, bump the edge, then pull the last word
        script_op(FN_NEXT,   32'h0);
        script_op(FN_NEXT,   32'h0);
        script_op(FN_GET,    32'h0);
        script_op(FN_REMOVE, 32'h0);
        script_op(FN_PRIOR,  32'h0);
        script_op(FN_PRIOR,  32'h0);
        script_op(FN_END,    32'h0);
        script_op(FN_BEGIN,  32'h0);
        script_op(FN_UNUSED_LO, 32'h0);
        // capacity dropped under the count blocks inserts, then capacity zero
        script_capacity(7'd1);
        script_op(FN_INS_BEFORE, 32'h0);
        script_capacity(7'd0);
        script_op(FN_INS_AFTER, 32'h0000_0001);
        script_op(FN_REMOVE, 32'h0);
        script_typed(FN_CLEAR, 32'h0, 1'b1, 32'h0, 7'd0, 6'd0);
        script_typed(FN_CLEAR, 32'h0, 1'b1, 32'h0, 7'd0, 6'd0);
        // capacity above the store depth saturates
        script_capacity(7'd127);
        script_op(FN_INS_BEFORE, 32'h5555_5555);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 0;
        foreach (script[k]) begin
            if (script[k].cap_write)
                set_capacity(script[k].cap);
            else
                send_item(script[k].func, script[k].value, script[k].typed, script[k].want);
        end

        // random part: capacity extremes and a few idle mixes on the sender
        run_phase(CAP_RESET, 0, 320);
        run_phase(7'd127, 68, 300);
        run_phase(7'd1, 27, 150);
        run_phase(7'd0, 0, 60);
        run_phase(CAP_W'($urandom_range(12, 2)), 68, 220);
        run_phase(CAP_W'($urandom_range(127, 1)), 27, 250);

        // drain: wait out every result, then a short quiet tail
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0 || busy)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> cursor_list_array.f
rtl/cla_pkg.sv
rtl/cla_ram.sv
rtl/cla_ctrl.sv
rtl/cla_dp.sv
rtl/cursor_list_array.sv
tb/cursor_list_array_tb.sv
